>>> hdl/key_matrix_debounce_dispatch_defines.svh
// Assertion macros used by the RTL in kmdd_merge.
`ifndef KEY_MATRIX_DEBOUNCE_DISPATCH_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_DISPATCH_DEFINES_SVH

// Checked only out of reset.
`define KMDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kmdd assertion failed");

// Checked during reset as well.
`define KMDD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("kmdd assertion failed");

`endif

>>> hdl/kmdd_pkg.sv
package kmdd_pkg;

  localparam int ROWS_DEF       = 3;
  localparam int COLS_DEF       = 3;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int PRESSED_W   = 9;
  localparam int NOW_W       = 32;
  localparam int DEBOUNCE_W  = 16;
  localparam int ACT_KEYS_W  = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int KEYNUM_W    = 4;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 4;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [ACT_KEYS_W-1:0] ACT_KEYS_RST   = 4'd6;
  localparam logic [CNT_W-1:0]      MAX_RESULTS    = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_KEYS = 1'b1;

  localparam logic [KEYNUM_W-1:0] KEY_MODE   = 4'd7;
  localparam logic [KEYNUM_W-1:0] KEY_PAUSE  = 4'd8;
  localparam logic [KEYNUM_W-1:0] KEY_RECORD = 4'd9;

  typedef enum logic [2:0] {
    ACT_SCENE  = 3'd0,
    ACT_SOURCE = 3'd1,
    ACT_MODE   = 3'd2,
    ACT_PAUSE  = 3'd3,
    ACT_RECORD = 3'd4
  } kmdd_act_e;

  // merge status toward the input handshake
  typedef struct packed {
    logic busy;      // a request's results are still being sent
    logic finish;    // the final result of that request is taken this cycle
  } kmdd_flow_t;

endpackage

>>> hdl/key_matrix_debounce_dispatch.sv
// Channel  Dir  Handshake                 Payload
// scan     in   in_valid_i / in_stall_o   pressed_keys_i, now_ms_i
// result   out  out_valid_o / out_stall_i key_number_o, action_o, slot_o,
//                                         source_mode_now_o, last_o
// config   in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A request is debounced by one lane per key in the cycle it is accepted.
// Its results leave the output register one per cycle while out_stall_i is low, lowest key first,
// so a request occupies the merge stage until its last result is taken (not at all if none).
// The next request is taken as the final result of the previous one enters the output register.
// Async active-low reset: all keys released, scene mode, registers at defaults.
// out_stall_i holds the output register and, through it, the input.
module key_matrix_debounce_dispatch #(
  parameter int ROWS       = kmdd_pkg::ROWS_DEF,
  parameter int COLS       = kmdd_pkg::COLS_DEF,
  parameter int TIME_WIDTH = kmdd_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kmdd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kmdd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kmdd_pkg::PRESSED_W-1:0]  pressed_keys_i,
  input  logic [kmdd_pkg::NOW_W-1:0]      now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kmdd_pkg::KEYNUM_W-1:0]   key_number_o,
  output logic [2:0]                      action_o,
  output logic [kmdd_pkg::SLOT_W-1:0]     slot_o,
  output logic                            source_mode_now_o,
  output logic                            last_o
);
  import kmdd_pkg::*;

  localparam int NKEYS = ROWS * COLS;

  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [ACT_KEYS_W-1:0] action_keys_q;
  logic [NKEYS-1:0]      lane_pressed;
  logic [NKEYS-1:0]      fire;
  logic                  accept;
  kmdd_flow_t            flow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEBOUNCE_RST;
      action_keys_q <= ACT_KEYS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q    <= cfg_data_i[DEBOUNCE_W-1:0];
        CFG_ACT_KEYS: action_keys_q <= cfg_data_i[ACT_KEYS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = flow.busy && !flow.finish;
  assign accept     = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < NKEYS; i++) begin : g_lane
    if (i < PRESSED_W) begin : g_pin
      assign lane_pressed[i] = pressed_keys_i[i];
    end else begin : g_none
      assign lane_pressed[i] = 1'b0;
    end

    kmdd_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .load_i    (accept),
      .pressed_i (lane_pressed[i]),
      .now_i     (now_ms_i[TIME_WIDTH-1:0]),
      .debounce_i(debounce_q),
      .fire_o    (fire[i])
    );
  end

  kmdd_merge #(
    .NKEYS(NKEYS)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .fire_i           (fire),
    .action_keys_i    (action_keys_q),
    .out_stall_i      (out_stall_i),
    .flow_o           (flow),
    .out_valid_o      (out_valid_o),
    .key_number_o     (key_number_o),
    .action_o         (action_o),
    .slot_o           (slot_o),
    .source_mode_now_o(source_mode_now_o),
    .last_o           (last_o)
  );

endmodule

>>> hdl/kmdd_lane.sv
module kmdd_lane #(
  parameter int TIME_WIDTH = kmdd_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic                              pressed_i,
  input  logic [TIME_WIDTH-1:0]             now_i,
  input  logic [kmdd_pkg::DEBOUNCE_W-1:0]   debounce_i,
  output logic                              fire_o
);
  import kmdd_pkg::*;

  logic                  level_q, level_d;
  logic                  fired_q, fired_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic                  change;
  logic                  fired_arm;
  logic [TIME_WIDTH-1:0] held;

  always_comb begin
    change    = pressed_i != level_q;
    time_d    = change ? now_i : time_q;
    fired_arm = (change && !pressed_i) ? 1'b0 : fired_q;
    held      = now_i - time_d;
    fire_o    = pressed_i && !fired_arm && (held >= TIME_WIDTH'(debounce_i));
    level_d   = pressed_i;
    fired_d   = fired_arm || fire_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      fired_q <= 1'b0;
      time_q  <= '0;
    end else if (load_i) begin
      level_q <= level_d;
      fired_q <= fired_d;
      time_q  <= time_d;
    end
  end

endmodule

>>> hdl/kmdd_merge.sv
`include "key_matrix_debounce_dispatch_defines.svh"

module kmdd_merge #(
  parameter int NKEYS = kmdd_pkg::ROWS_DEF * kmdd_pkg::COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [NKEYS-1:0]                fire_i,
  input  logic [kmdd_pkg::ACT_KEYS_W-1:0] action_keys_i,
  input  logic                            out_stall_i,
  output kmdd_pkg::kmdd_flow_t            flow_o,
  output logic                            out_valid_o,
  output logic [kmdd_pkg::KEYNUM_W-1:0]   key_number_o,
  output logic [2:0]                      action_o,
  output logic [kmdd_pkg::SLOT_W-1:0]     slot_o,
  output logic                            source_mode_now_o,
  output logic                            last_o
);
  import kmdd_pkg::*;

  localparam int IdxW = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int KnW  = ($clog2(NKEYS + 1) > KEYNUM_W) ? $clog2(NKEYS + 1) : KEYNUM_W;

  logic [NKEYS-1:0]    emit;
  logic [NKEYS-1:0]    mask_q, mask_d;
  logic [NKEYS-1:0]    low, rest;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                mode_q, mode_d;
  logic [IdxW-1:0]     idx;
  logic [KnW-1:0]      kn, kn_i;
  logic [KnW-1:0]      act_keys_w;
  logic                adv, take, last_now;
  kmdd_act_e           act;
  logic [SLOT_W-1:0]   slot;

  logic                out_valid_q, out_valid_d;
  logic [KEYNUM_W-1:0] key_number_q;
  kmdd_act_e           action_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                mode_now_q;
  logic                last_q;

  assign act_keys_w = KnW'(action_keys_i);

  always_comb begin
    emit = '0;
    for (int i = 0; i < NKEYS; i++) begin
      kn_i = KnW'(i + 1);
      emit[i] = fire_i[i] && ((kn_i <= act_keys_w) || (kn_i == KnW'(KEY_MODE)) ||
                (kn_i == KnW'(KEY_PAUSE)) || (kn_i == KnW'(KEY_RECORD)));
    end
  end

  // lowest pending key
  always_comb begin
    low  = mask_q & (~mask_q + NKEYS'(1));
    rest = mask_q & ~low;
    idx  = '0;
    for (int i = 0; i < NKEYS; i++) begin
      if (low[i]) idx = idx | IdxW'(i);
    end
    kn = KnW'(idx) + KnW'(1);
  end

  always_comb begin
    act    = ACT_SCENE;
    slot   = '0;
    mode_d = mode_q;
    if (kn <= act_keys_w) begin
      act  = mode_q ? ACT_SOURCE : ACT_SCENE;
      slot = SLOT_W'(kn - KnW'(1));
    end else if (kn == KnW'(KEY_MODE)) begin
      act    = ACT_MODE;
      mode_d = !mode_q;
    end else if (kn == KnW'(KEY_PAUSE)) begin
      act = ACT_PAUSE;
    end else begin
      act = ACT_RECORD;
    end
  end

  always_comb begin
    adv         = !out_valid_q || !out_stall_i;
    take        = (mask_q != '0) && adv;
    last_now    = (rest == '0) || (cnt_q == MAX_RESULTS - CNT_W'(1));
    out_valid_d = take || (out_valid_q && out_stall_i);
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    if (take) begin
      mask_d = last_now ? '0 : rest;
      cnt_d  = cnt_q + CNT_W'(1);
    end
    if (load_i) begin
      mask_d = emit;
      cnt_d  = '0;
    end
    flow_o.busy   = mask_q != '0;
    flow_o.finish = take && last_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (take) mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_number_q <= kn[KEYNUM_W-1:0];
      action_q     <= act;
      slot_q       <= slot;
      mode_now_q   <= mode_d;
      last_q       <= last_now;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_number_o      = key_number_q;
  assign action_o          = action_q;
  assign slot_o            = slot_q;
  assign source_mode_now_o = mode_now_q;
  assign last_o            = last_q;

  `KMDD_ASSERT(a_slot_match, (out_valid_q && (action_q == ACT_SCENE || action_q == ACT_SOURCE)) |-> (slot_q == key_number_q - KEYNUM_W'(1)))
  `KMDD_ASSERT(a_mode_key, (out_valid_q && action_q == ACT_MODE) |-> (key_number_q == KEY_MODE && slot_q == '0))
  `KMDD_ASSERT_ALWAYS(a_cnt_cap, cnt_q <= MAX_RESULTS)

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import kmdd_pkg::*;

  localparam int KEY_COUNT      = ROWS_DEF * COLS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PRESSED_W-1:0]  pressed_keys_i;
  logic [NOW_W-1:0]      now_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [KEYNUM_W-1:0]   key_number_o;
  logic [2:0]            action_o;
  logic [SLOT_W-1:0]     slot_o;
  logic                  source_mode_now_o;
  logic                  last_o;

  key_matrix_debounce_dispatch dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pressed_keys_i   (pressed_keys_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_number_o     (key_number_o),
    .action_o         (action_o),
    .slot_o           (slot_o),
    .source_mode_now_o(source_mode_now_o),
    .last_o           (last_o)
  );

  typedef struct {
    logic [KEYNUM_W-1:0] key_number;
    kmdd_act_e           action;
    logic [SLOT_W-1:0]   slot;
    logic                source_mode;
    logic                last;
  } key_action_t;

  class key_action_scoreboard;
    logic [DEBOUNCE_W-1:0] debounce;
    logic [ACT_KEYS_W-1:0] act_keys;
    logic                  level[KEY_COUNT];
    logic [NOW_W-1:0]      change_at[KEY_COUNT];
    logic                  fired[KEY_COUNT];
    logic                  source_mode;
    key_action_t           pending_q[$];
    int                    mismatches;

    function new();
      debounce    = DEBOUNCE_RST;
      act_keys    = ACT_KEYS_RST;
      source_mode = 1'b0;
      mismatches  = 0;
      for (int i = 0; i < KEY_COUNT; i++) begin
        level[i]     = 1'b0;
        change_at[i] = '0;
        fired[i]     = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DEBOUNCE) begin
        debounce = data[DEBOUNCE_W-1:0];
      end else if (idx == CFG_ACT_KEYS) begin
        act_keys = data[ACT_KEYS_W-1:0];
      end
    endfunction

    // debounce one request and queue the key actions it fires, lowest key first
    function void note_scan(logic [PRESSED_W-1:0] keys, logic [NOW_W-1:0] now);
      key_action_t fresh[$];
      key_action_t a;
      logic [NOW_W-1:0] held;
      logic [KEYNUM_W-1:0] kn;
      bit emit;
      for (int i = 0; i < KEY_COUNT; i++) begin
        if (keys[i] != level[i]) begin
          change_at[i] = now;
          level[i]     = keys[i];
          if (!keys[i]) fired[i] = 1'b0;
        end
        held = now - change_at[i];
        if (keys[i] && !fired[i] && held >= NOW_W'(debounce)) begin
          kn           = KEYNUM_W'(i + 1);
          a.key_number = kn;
          a.slot       = '0;
          a.last       = 1'b0;
          emit         = 1'b1;
          if (kn >= 1 && kn <= KEYNUM_W'(act_keys)) begin
            a.action = source_mode ? ACT_SOURCE : ACT_SCENE;
            a.slot   = SLOT_W'(kn - 1);
          end else if (kn == KEY_MODE) begin
            source_mode = ~source_mode;
            a.action    = ACT_MODE;
          end else if (kn == KEY_PAUSE) begin
            a.action = ACT_PAUSE;
          end else if (kn == KEY_RECORD) begin
            a.action = ACT_RECORD;
          end else begin
            emit = 1'b0;
          end
          if (emit) begin
            a.source_mode = source_mode;
            fresh.push_back(a);
          end
          fired[i] = 1'b1;
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[j]) pending_q.push_back(fresh[j]);
    endfunction

    function void check_result(logic [KEYNUM_W-1:0] kn, logic [2:0] act,
                               logic [SLOT_W-1:0] slot, logic sm, logic last);
      key_action_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result key %0d act %0d slot %0d mode %0b last %0b",
                   $realtime, kn, act, slot, sm, last);
        return;
      end
      e = pending_q.pop_front();
      if (kn !== e.key_number || act !== e.action || slot !== e.slot ||
          sm !== e.source_mode || last !== e.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: exp key %0d act %0d slot %0d mode %0b last %0b, got %0d %0d %0d %0b %0b",
                   $realtime, e.key_number, e.action, e.slot, e.source_mode, e.last,
                   kn, act, slot, sm, last);
      end
    endfunction
  endclass

  key_action_scoreboard sb = new();

  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  int idle_cycles = 0;
  logic [PRESSED_W-1:0] cur_keys = '0;
  logic [NOW_W-1:0]     cur_now  = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_scan(pressed_keys_i, now_ms_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(key_number_o, action_o, slot_o, source_mode_now_o, last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int run;
    int hold_left;
    int r;
    run         = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (run > 0) begin
        run--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(0, 7);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // called on a falling edge, returns on a falling edge
  task automatic send_scan(logic [PRESSED_W-1:0] keys, logic [NOW_W-1:0] t);
    int gap;
    in_valid_i     <= 1'b1;
    pressed_keys_i <= keys;
    now_ms_i       <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic [DEBOUNCE_W-1:0] db, logic [ACT_KEYS_W-1:0] ak);
    logic [CFG_DATA_W-ACT_KEYS_W-1:0] junk;
    junk = (CFG_DATA_W-ACT_KEYS_W)'($urandom);
    drain();
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_ACT_KEYS, {junk, ak});
  endtask

  task automatic run_phase(logic [DEBOUNCE_W-1:0] db, logic [ACT_KEYS_W-1:0] ak,
                           int count, logic [NOW_W-1:0] start);
    int tick;
    int r;
    configure(db, ak);
    cur_now = start;
    tick    = db / 3 + 2;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r >= 65 && r < 92) begin
        cur_keys[$urandom_range(0, KEY_COUNT-1)] ^= 1'b1;
        if ($urandom_range(0, 1)) cur_keys[$urandom_range(0, KEY_COUNT-1)] ^= 1'b1;
      end else if (r >= 92) begin
        cur_keys = PRESSED_W'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 99) < 4) begin
        cur_now = $urandom;
      end else begin
        cur_now = cur_now + NOW_W'($urandom_range(0, tick));
      end
      send_scan(cur_keys, cur_now);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    pressed_keys_i = '0;
    now_ms_i       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults: debounce 50, keys 1..6 act
    send_scan(9'h000, 32'd0);
    send_scan(9'h1FF, 32'd100);
    send_scan(9'h1FF, 32'd149);
    send_scan(9'h1FF, 32'd150);
    send_scan(9'h1FF, 32'd400);
    send_scan(9'h000, 32'd410);
    send_scan(9'h001, 32'd420);
    send_scan(9'h001, 32'd470);
    send_scan(9'h040, 32'd480);
    send_scan(9'h040, 32'd530);
    // zero debounce, keys 7..9 in action range
    configure(16'd0, 4'd9);
    send_scan(9'h1C0, 32'd540);
    send_scan(9'h000, 32'd541);
    // no action keys, longest debounce
    configure(16'hFFFF, 4'd0);
    send_scan(9'h1FF, 32'hFFFF_0000);
    send_scan(9'h1FF, 32'hFFFF_FFFF);
    send_scan(9'h000, 32'h0000_0000);
    // action range past the matrix, time wrap
    configure(16'd100, 4'd15);
    send_scan(9'h1FF, 32'hFFFF_FFE0);
    send_scan(9'h1FF, 32'h0000_0044);
    send_scan(9'h000, 32'd50);
    send_scan(9'h1FF, 32'd200);
    send_scan(9'h0FF, 32'd250);
    send_scan(9'h1FF, 32'd320);
    send_scan(9'h1FF, 32'd420);

    run_phase(16'd50, 4'd6, 27, $urandom);
    calm = 1'b1;
    run_phase(16'd0, 4'd9, 25, $urandom);
    calm = 1'b0;
    run_phase(16'd3, 4'd0, 27, 32'hFFFF_FFC0);
    run_phase(16'hFFFF, 4'd15, 27, $urandom);
    run_phase(16'($urandom_range(1, 20)), 4'($urandom_range(0, 15)), 27, $urandom);

    // long output hold while requests keep coming
    configure(16'd0, 4'($urandom_range(0, 15)));
    hold_req = 1'b1;
    calm     = 1'b1;
    repeat (2) @(negedge clk_i);
    for (int k = 0; k < 8; k++) begin
      cur_now = cur_now + 1;
      send_scan((k % 2 == 0) ? 9'h1FF : 9'h000, cur_now);
    end
    drain();

    run_phase(16'd10, 4'd7, 25, 32'h7FFF_FFF0);
    calm = 1'b0;
    run_phase(16'($urandom), 4'($urandom_range(0, 15)), 27, $urandom);

    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
